@@ src/e1ts0_pkg.sv @@
// Shared constants and helper functions for the E1 timeslot-zero alarm monitor.
`default_nettype none

package e1ts0_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned FRAME_W = 4;
    localparam int unsigned CNT_W   = 32;

    localparam logic [BYTE_W-1:0]  SA_FILL_MASK     = 8'he0;
    localparam int unsigned        ALARM_BIT_IDX    = 5;
    localparam int unsigned        EBIT_IDX         = 7;
    localparam logic [FRAME_W-1:0] FRAME_EBIT_FIRST = 4'd13;
    localparam logic [FRAME_W-1:0] FRAME_EBIT_LAST  = 4'd15;
    localparam logic [1:0]         EBIT_PAIR_GOOD   = 2'b11;

    typedef logic [BYTE_W-1:0]  byte_t;
    typedef logic [FRAME_W-1:0] frame_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // Sa8->7, Sa7->6, Sa5->5, Sa4->4, Sa6->0
    function automatic byte_t repack_sa(input byte_t b);
        byte_t r;
        r    = '0;
        r[7] = b[0];
        r[6] = b[1];
        r[0] = b[2];
        r[5] = b[3];
        r[4] = b[4];
        return r;
    endfunction

    function automatic cnt_t sat_inc(input cnt_t v);
        cnt_t r;
        r = (v == '1) ? v : v + cnt_t'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ src/e1_ts0_alarm_monitor.sv @@
// E1 timeslot-zero monitor: remote alarm, Sa bit change and E bit error tracking.
//
//   channel | direction | handshake          | beat contents
//   --------+-----------+--------------------+-------------------------------------------
//   in      | to block  | in_valid/in_stall  | ts0_byte, frame_number, clear_crc_error
//   out     | from block| out_valid/out_stall| events, sa_bits, flags, two 32-bit counters
//
// One input beat per clock while in_stall is low; a taken input passes through the
// input register, then the result register, before it appears on the out channel.
// State is updated when an item moves from the input register to the result
// register. rst_n clears all flags, counters, the E bit pair and the stored Sa octet.
// A stalled result register holds its beat, and the input register then fills and
// raises in_stall.
`default_nettype none

module e1_ts0_alarm_monitor
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire e1ts0_pkg::byte_t        ts0_byte,
    input  wire e1ts0_pkg::frame_t       frame_number,
    input  wire logic                    clear_crc_error,

    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         alarm_on_event,
    output logic                         alarm_off_event,
    output logic                         sa_changed_event,
    output e1ts0_pkg::byte_t             sa_bits,
    output logic                         ebit_error_event,
    output logic                         alarm_active,
    output logic                         crc_error_active,
    output e1ts0_pkg::cnt_t              alarm_count,
    output e1ts0_pkg::cnt_t              ebit_error_count
);

    import e1ts0_pkg::*;

    // input register
    logic   in_vld_reg;
    byte_t  byte_reg;
    frame_t frame_reg;
    logic   clr_reg;

    // block state
    logic       alarm_flag_reg,  alarm_flag_next;
    logic       crc_flag_reg,    crc_flag_next;
    byte_t      last_sa_reg,     last_sa_next;
    logic [1:0] ebit_pair_reg,   ebit_pair_next;
    cnt_t       alarm_cnt_reg,   alarm_cnt_next;
    cnt_t       ebit_cnt_reg,    ebit_cnt_next;

    // result register
    logic  out_vld_reg;
    logic  on_ev_reg,  on_ev_next;
    logic  off_ev_reg, off_ev_next;
    logic  sa_ev_reg,  sa_ev_next;
    byte_t sa_reg,     sa_next;
    logic  e_ev_reg,   e_ev_next;

    logic  advance;
    logic  in_take;
    logic  odd_frame;
    logic  alarm_bit;
    logic  ebit;
    byte_t filled;

    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        odd_frame = frame_reg[0];
        alarm_bit = byte_reg[ALARM_BIT_IDX];
        ebit      = byte_reg[EBIT_IDX];
        filled    = byte_reg | SA_FILL_MASK;

        crc_flag_next   = clr_reg ? 1'b0 : crc_flag_reg;
        alarm_flag_next = alarm_flag_reg;
        alarm_cnt_next  = alarm_cnt_reg;
        last_sa_next    = last_sa_reg;
        ebit_pair_next  = ebit_pair_reg;
        ebit_cnt_next   = ebit_cnt_reg;
        on_ev_next      = 1'b0;
        off_ev_next     = 1'b0;
        sa_ev_next      = 1'b0;
        sa_next         = '0;
        e_ev_next       = 1'b0;

        if (odd_frame)
        begin
            on_ev_next      = alarm_bit && !alarm_flag_reg;
            off_ev_next     = !alarm_bit && alarm_flag_reg;
            alarm_flag_next = alarm_bit;
            if (on_ev_next)
            begin
                alarm_cnt_next = sat_inc(alarm_cnt_reg);
            end
            if (last_sa_reg != filled)
            begin
                sa_ev_next   = 1'b1;
                sa_next      = repack_sa(byte_reg);
                last_sa_next = filled;
            end
        end

        if (frame_reg == FRAME_EBIT_FIRST)
        begin
            ebit_pair_next = {ebit, 1'b0};
        end
        if (frame_reg == FRAME_EBIT_LAST)
        begin
            ebit_pair_next = ebit_pair_reg | {1'b0, ebit};
            if (ebit_pair_next != EBIT_PAIR_GOOD)
            begin
                e_ev_next     = 1'b1;
                crc_flag_next = 1'b1;
                ebit_cnt_next = sat_inc(ebit_cnt_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
            alarm_flag_reg <= 1'b0;
            crc_flag_reg   <= 1'b0;
            last_sa_reg    <= '0;
            ebit_pair_reg  <= '0;
            alarm_cnt_reg  <= '0;
            ebit_cnt_reg   <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg    <= 1'b1;
                alarm_flag_reg <= alarm_flag_next;
                crc_flag_reg   <= crc_flag_next;
                last_sa_reg    <= last_sa_next;
                ebit_pair_reg  <= ebit_pair_next;
                alarm_cnt_reg  <= alarm_cnt_next;
                ebit_cnt_reg   <= ebit_cnt_next;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            byte_reg  <= ts0_byte;
            frame_reg <= frame_number;
            clr_reg   <= clear_crc_error;
        end
        if (advance)
        begin
            on_ev_reg  <= on_ev_next;
            off_ev_reg <= off_ev_next;
            sa_ev_reg  <= sa_ev_next;
            sa_reg     <= sa_next;
            e_ev_reg   <= e_ev_next;
        end
    end

    assign out_valid        = out_vld_reg;
    assign alarm_on_event   = on_ev_reg;
    assign alarm_off_event  = off_ev_reg;
    assign sa_changed_event = sa_ev_reg;
    assign sa_bits          = sa_reg;
    assign ebit_error_event = e_ev_reg;
    assign alarm_active     = alarm_flag_reg;
    assign crc_error_active = crc_flag_reg;
    assign alarm_count      = alarm_cnt_reg;
    assign ebit_error_count = ebit_cnt_reg;

    a_on_off_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(alarm_on_event && alarm_off_event))
        else $error("alarm on and off in one beat");

    a_sa_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !sa_changed_event) |-> (sa_bits == '0))
        else $error("sa_bits nonzero without change");

    a_ebit_sets_crc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ebit_error_event) |-> crc_error_active)
        else $error("E bit error without CRC flag");

    a_on_sets_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && alarm_on_event) |-> (alarm_active && alarm_count != '0))
        else $error("alarm onset without alarm flag or count");

endmodule

`default_nettype wire

@@ tb/sv/e1_ts0_alarm_monitor_test.sv @@
// Self-checking testbench for the E1 timeslot-zero alarm, Sa and E bit monitor.
module e1_ts0_alarm_monitor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import e1ts0_pkg::*;

    typedef struct packed {
        logic   alarm_on;
        logic   alarm_off;
        logic   sa_changed;
        byte_t  sa_val;
        logic   ebit_err;
        logic   alarm_act;
        logic   crc_act;
        cnt_t   alarm_cnt;
        cnt_t   ebit_cnt;
    } ts0_result_t;

    typedef struct packed {
        byte_t       octet;
        frame_t      frame;
        logic        clr;
        logic        typed;
        ts0_result_t want;
    } frame_row_t;

    localparam ts0_result_t NO_WANT = '0;
    localparam int unsigned N_ROWS = 26;
    localparam frame_row_t FRAME_ROWS [0:N_ROWS-1] = '{
        '{8'h00, 4'd0,  1'b0, 1'b1, '{1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0}},
        '{8'h20, 4'd1,  1'b0, 1'b1, '{1'b1, 1'b0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b0, 32'd1, 32'd0}},
        '{8'hff, 4'd13, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 8'hf1, 1'b0, 1'b1, 1'b0, 32'd1, 32'd0}},
        '{8'h00, 4'd15, 1'b0, 1'b1, '{1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0, 1'b1, 32'd1, 32'd1}},
        '{8'h80, 4'd15, 1'b1, 1'b0, NO_WANT},
        '{8'h80, 4'd15, 1'b0, 1'b0, NO_WANT},
        '{8'h00, 4'd13, 1'b0, 1'b0, NO_WANT},
        '{8'h80, 4'd15, 1'b1, 1'b0, NO_WANT},
        '{8'h80, 4'd15, 1'b0, 1'b0, NO_WANT},
        '{8'hff, 4'd14, 1'b0, 1'b0, NO_WANT},
        '{8'h1f, 4'd3,  1'b0, 1'b0, NO_WANT},
        '{8'h1f, 4'd5,  1'b0, 1'b0, NO_WANT},
        '{8'hff, 4'd7,  1'b0, 1'b0, NO_WANT},
        '{8'h01, 4'd9,  1'b0, 1'b0, NO_WANT},
        '{8'h02, 4'd11, 1'b0, 1'b0, NO_WANT},
        '{8'h04, 4'd1,  1'b0, 1'b0, NO_WANT},
        '{8'h08, 4'd3,  1'b0, 1'b0, NO_WANT},
        '{8'h10, 4'd5,  1'b0, 1'b0, NO_WANT},
        '{8'h80, 4'd13, 1'b0, 1'b0, NO_WANT},
        '{8'ha0, 4'd15, 1'b0, 1'b0, NO_WANT},
        '{8'h55, 4'd2,  1'b1, 1'b0, NO_WANT},
        '{8'haa, 4'd8,  1'b0, 1'b0, NO_WANT},
        '{8'h20, 4'd4,  1'b0, 1'b0, NO_WANT},
        '{8'he0, 4'd6,  1'b0, 1'b0, NO_WANT},
        '{8'hff, 4'd10, 1'b0, 1'b0, NO_WANT},
        '{8'h7f, 4'd12, 1'b0, 1'b0, NO_WANT}
    };

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    byte_t  ts0_byte = '0;
    frame_t frame_number = '0;
    logic   clear_crc_error = 1'b0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    logic   alarm_on_event;
    logic   alarm_off_event;
    logic   sa_changed_event;
    byte_t  sa_bits;
    logic   ebit_error_event;
    logic   alarm_active;
    logic   crc_error_active;
    cnt_t   alarm_count;
    cnt_t   ebit_error_count;

    // predicted monitor state
    logic   alarm_st;
    logic   crc_st;
    byte_t  sa_last;
    logic [1:0] epair;
    cnt_t   alarm_tally;
    cnt_t   ebit_tally;

    ts0_result_t pending_results [$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int frames_sent = 0;
    int results_seen = 0;
    int onsets_seen = 0;
    int ebit_errs_seen = 0;

    e1_ts0_alarm_monitor dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .ts0_byte         (ts0_byte),
        .frame_number     (frame_number),
        .clear_crc_error  (clear_crc_error),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .alarm_on_event   (alarm_on_event),
        .alarm_off_event  (alarm_off_event),
        .sa_changed_event (sa_changed_event),
        .sa_bits          (sa_bits),
        .ebit_error_event (ebit_error_event),
        .alarm_active     (alarm_active),
        .crc_error_active (crc_error_active),
        .alarm_count      (alarm_count),
        .ebit_error_count (ebit_error_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic ts0_result_t predict_ts0(byte_t oct, frame_t fr, logic clr);
        ts0_result_t r;
        byte_t       filled;
        r = '0;
        filled = oct | SA_FILL_MASK;
        if (clr)
            crc_st = 1'b0;
        if (fr[0])
        begin
            if (oct[ALARM_BIT_IDX])
            begin
                if (!alarm_st)
                begin
                    alarm_st = 1'b1;
                    alarm_tally = (alarm_tally == '1) ? alarm_tally : alarm_tally + 1;
                    r.alarm_on = 1'b1;
                end
            end
            else if (alarm_st)
            begin
                alarm_st = 1'b0;
                r.alarm_off = 1'b1;
            end
            if (sa_last != filled)
            begin
                sa_last = filled;
                r.sa_changed = 1'b1;
                r.sa_val = {oct[0], oct[1], oct[3], oct[4], 3'b000, oct[2]};
            end
        end
        if (fr == FRAME_EBIT_FIRST)
            epair = {oct[EBIT_IDX], 1'b0};
        if (fr == FRAME_EBIT_LAST)
        begin
            epair = epair | {1'b0, oct[EBIT_IDX]};
            if (epair != EBIT_PAIR_GOOD)
            begin
                crc_st = 1'b1;
                ebit_tally = (ebit_tally == '1) ? ebit_tally : ebit_tally + 1;
                r.ebit_err = 1'b1;
            end
        end
        r.alarm_act = alarm_st;
        r.crc_act = crc_st;
        r.alarm_cnt = alarm_tally;
        r.ebit_cnt = ebit_tally;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // caller is at a rising edge; returns at the edge the beat is taken
    task automatic send_ts0(byte_t oct, frame_t fr, logic clr, logic typed,
                            ts0_result_t want);
        ts0_result_t calc;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        ts0_byte <= oct;
        frame_number <= fr;
        clear_crc_error <= clr;
        do
            @(posedge clk);
        while (in_stall);
        calc = predict_ts0(oct, fr, clr);
        pending_results.push_back(typed ? want : calc);
        frames_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);

    always @(posedge clk)
    begin
        ts0_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            onsets_seen += int'(alarm_on_event);
            ebit_errs_seen += int'(ebit_error_event);
            if (pending_results.size() == 0)
            begin
                $error("result beat with no expectation pending");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("alarm_on_event", 32'(want.alarm_on), 32'(alarm_on_event));
                check_field("alarm_off_event", 32'(want.alarm_off), 32'(alarm_off_event));
                check_field("sa_changed_event", 32'(want.sa_changed),
                            32'(sa_changed_event));
                check_field("sa_bits", 32'(want.sa_val), 32'(sa_bits));
                check_field("ebit_error_event", 32'(want.ebit_err), 32'(ebit_error_event));
                check_field("alarm_active", 32'(want.alarm_act), 32'(alarm_active));
                check_field("crc_error_active", 32'(want.crc_act), 32'(crc_error_active));
                check_field("alarm_count", want.alarm_cnt, alarm_count);
                check_field("ebit_error_count", want.ebit_cnt, ebit_error_count);
            end
        end
    end

    initial
    begin
        int          idle_plan [4];
        int          stall_plan [4];
        logic        alarm_line;
        logic [4:0]  sa_line;
        logic        in_order;
        byte_t       oct;
        frame_t      fr;

        idle_plan = '{0, 69, 0, 14};
        stall_plan = '{0, 0, 69, 14};
        alarm_st = 1'b0;
        crc_st = 1'b0;
        sa_last = '0;
        epair = '0;
        alarm_tally = '0;
        ebit_tally = '0;
        alarm_line = 1'b0;
        sa_line = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_ROWS; i++)
            send_ts0(FRAME_ROWS[i].octet, FRAME_ROWS[i].frame, FRAME_ROWS[i].clr,
                     FRAME_ROWS[i].typed, FRAME_ROWS[i].want);
        drain_results();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_plan[ph];
            recv_stall_pct = stall_plan[ph];
            for (int mf = 0; mf < 24; mf++)
            begin
                // mostly ordered multiframes, some with scrambled frame numbers
                in_order = ($urandom_range(0, 99) < 85);
                for (int k = 0; k < 16; k++)
                begin
                    fr = in_order ? frame_t'(k) : frame_t'($urandom_range(0, 15));
                    if ($urandom_range(0, 99) < 8)
                        alarm_line = ~alarm_line;
                    if ($urandom_range(0, 99) < 12)
                        sa_line = 5'($urandom);
                    oct = byte_t'($urandom);
                    if (fr[0])
                    begin
                        oct[ALARM_BIT_IDX] = alarm_line;
                        oct[4:0] = sa_line;
                    end
                    if (fr == FRAME_EBIT_FIRST || fr == FRAME_EBIT_LAST)
                        oct[EBIT_IDX] = ($urandom_range(0, 99) < 85);
                    send_ts0(oct, fr, ($urandom_range(0, 99) < 4), 1'b0, NO_WANT);
                end
            end
            // sender holds off until the block has emptied
            drain_results();
        end

        repeat (10) @(posedge clk);
        $display("Sent %0d frames over four idle/stall mixes; %0d results checked.",
                 frames_sent, results_seen);
        $display("Seen %0d alarm onsets and %0d E bit error multiframes.",
                 onsets_seen, ebit_errs_seen);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ sim.f @@
src/e1ts0_pkg.sv
src/e1_ts0_alarm_monitor.sv
tb/sv/e1_ts0_alarm_monitor_test.sv
